/* design/nssfc_pkg.sv */
`timescale 1ns / 1ps

package nssfc_pkg;

  localparam int FRAME_BYTES   = 39;
  localparam int PATTERN_BYTES = 23;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int KIND_W = 2;
  localparam int FPOS_W = 6;
  localparam int MPOS_W = 5;
  localparam int HIST_AW = $clog2(FRAME_BYTES);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h01;
  localparam logic [BYTE_W-1:0] SUM_START   = BYTE_W'(SYNC_FIRST + SYNC_SECOND);
  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    EV_GOOD       = 2'd0,
    EV_BAD        = 2'd1,
    EV_INCOMPLETE = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e            event_kind;
    logic [FPOS_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   computed_sum;
    logic [BYTE_W-1:0]   received_sum;
    logic [CNT_W-1:0]    good_total;
    logic [CNT_W-1:0]    bad_total;
    logic [CNT_W-1:0]    incomplete_total;
    logic [CNT_W-1:0]    notify_total;
    logic [CNT_W-1:0]    payload_total;
    logic [CNT_W-1:0]    length_histogram_count;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [MPOS_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      5'd0:    b = "A";
      5'd1:    b = "T";
      5'd2:    b = "T";
      5'd3:    b = "_";
      5'd4:    b = "H";
      5'd5:    b = "A";
      5'd6:    b = "N";
      5'd7:    b = "D";
      5'd8:    b = "L";
      5'd9:    b = "E";
      5'd10:   b = "_";
      5'd11:   b = "V";
      5'd12:   b = "A";
      5'd13:   b = "L";
      5'd14:   b = "U";
      5'd15:   b = "E";
      5'd16:   b = "_";
      5'd17:   b = "N";
      5'd18:   b = "O";
      5'd19:   b = "T";
      5'd20:   b = "I";
      5'd21:   b = 8'h0D;
      5'd22:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/nssfc_in_if.sv */
`timescale 1ns / 1ps

interface nssfc_in_if import nssfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* design/nssfc_out_if.sv */
`timescale 1ns / 1ps

interface nssfc_out_if import nssfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [FPOS_W-1:0] frame_length;
  logic [BYTE_W-1:0] computed_sum;
  logic [BYTE_W-1:0] received_sum;
  logic [CNT_W-1:0]  good_total;
  logic [CNT_W-1:0]  bad_total;
  logic [CNT_W-1:0]  incomplete_total;
  logic [CNT_W-1:0]  notify_total;
  logic [CNT_W-1:0]  payload_total;
  logic [CNT_W-1:0]  length_histogram_count;

  modport source (
    output valid, output event_kind, output frame_length, output computed_sum,
    output received_sum, output good_total, output bad_total, output incomplete_total,
    output notify_total, output payload_total, output length_histogram_count,
    input ready
  );
  modport sink (
    input valid, input event_kind, input frame_length, input computed_sum,
    input received_sum, input good_total, input bad_total, input incomplete_total,
    input notify_total, input payload_total, input length_histogram_count,
    output ready
  );
endinterface

/* design/notify_strip_sync_frame_checker.sv */
`timescale 1ns / 1ps
// A byte that extends or completes a held notification prefix stays in S_IDLE. A byte that
// breaks a prefix of N held bytes, or reaches the framer itself, runs S_FEED once per framer
// step (N, plus 1 unless the byte restarts the prefix), S_HIST per incomplete frame
// (histogram read-modify-write), then S_DONE, which loads its beat, if any, into the output
// register, waiting while it is full and not taken. A new byte is accepted only in S_IDLE.
// Reset (rst_ni low, async): matcher, framer, counters and histogram valid bits cleared.

module notify_strip_sync_frame_checker import nssfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nssfc_in_if.sink    rx_i,
  nssfc_out_if.source ev_o
);

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_HIST, S_DONE} state_e;

  localparam logic [FPOS_W-1:0] LAST_POS  = FPOS_W'(FRAME_BYTES - 1);
  localparam logic [FPOS_W-1:0] FULL_LEN  = FPOS_W'(FRAME_BYTES);
  localparam logic [MPOS_W-1:0] PAT_LAST  = MPOS_W'(PATTERN_BYTES - 1);
  localparam logic [MPOS_W-1:0] PAT_FIRST = '0;

  state_e              state_q, state_d;
  logic [MPOS_W-1:0]   mpos_q, mpos_d;
  logic                in_frame_q, in_frame_d;
  logic                lws_q, lws_d;
  logic [FPOS_W-1:0]   fpos_q, fpos_d;
  logic [BYTE_W-1:0]   rsum_q, rsum_d;
  logic [CNT_W-1:0]    good_q, good_d;
  logic [CNT_W-1:0]    bad_q, bad_d;
  logic [CNT_W-1:0]    inc_q, inc_d;
  logic [CNT_W-1:0]    ntf_q, ntf_d;
  logic [CNT_W-1:0]    pay_q, pay_d;
  logic [MPOS_W-1:0]   rep_idx_q, rep_idx_d;
  logic [MPOS_W-1:0]   rep_cnt_q, rep_cnt_d;
  logic                cur_pend_q, cur_pend_d;
  logic [BYTE_W-1:0]   cur_q, cur_d;
  logic                ev_vld_q, ev_vld_d;
  ev_kind_e            ev_kind_q, ev_kind_d;
  logic [FPOS_W-1:0]   ev_len_q, ev_len_d;
  logic [BYTE_W-1:0]   ev_csum_q, ev_csum_d;
  logic [BYTE_W-1:0]   ev_rsum_q, ev_rsum_d;
  logic [CNT_W-1:0]    ev_hist_q, ev_hist_d;
  logic                hist_post_q, hist_post_d;
  logic [HIST_AW-1:0]  hist_idx_q, hist_idx_d;
  logic [FRAME_BYTES-1:0] hist_vld_q, hist_vld_d;
  logic                out_vld_q, out_vld_d;
  result_t             out_q, out_d;

  logic [CNT_W-1:0]    hist_mem [FRAME_BYTES];
  logic [CNT_W-1:0]    hist_rd_q;
  logic                hist_we;
  logic                hist_rd_en;
  logic [CNT_W-1:0]    hist_new;

  logic [BYTE_W-1:0]   feed;
  logic                fr_in_frame;
  logic                fr_lws;
  logic [FPOS_W-1:0]   fr_fpos;
  logic [BYTE_W-1:0]   fr_rsum;
  logic                fr_ev;
  ev_kind_e            fr_kind;
  logic [FPOS_W-1:0]   fr_len;

  assign feed = (rep_idx_q < rep_cnt_q) ? pattern_byte(rep_idx_q) : cur_q;

  // shared framer step: one byte per cycle in S_FEED, paused while S_HIST updates the histogram
  always_comb begin
    fr_in_frame = in_frame_q;
    fr_lws      = lws_q;
    fr_fpos     = fpos_q;
    fr_rsum     = rsum_q;
    fr_ev       = 1'b0;
    fr_kind     = EV_GOOD;
    fr_len      = '0;
    if (!in_frame_q) begin
      if (lws_q && feed == SYNC_SECOND) begin
        fr_in_frame = 1'b1;
        fr_fpos     = FPOS_W'(2);
        fr_rsum     = SUM_START;
        fr_lws      = 1'b0;
      end else begin
        fr_lws = (feed == SYNC_FIRST);
      end
    end else if (lws_q && feed == SYNC_SECOND) begin
      fr_ev       = 1'b1;
      fr_kind     = EV_INCOMPLETE;
      fr_len      = fpos_q - FPOS_W'(1);
      fr_in_frame = 1'b1;
      fr_fpos     = FPOS_W'(2);
      fr_rsum     = SUM_START;
      fr_lws      = 1'b0;
    end else if (fpos_q < LAST_POS) begin
      fr_rsum = rsum_q + feed;
      fr_fpos = fpos_q + FPOS_W'(1);
      fr_lws  = (feed == SYNC_FIRST);
    end else begin
      fr_ev       = 1'b1;
      fr_kind     = (rsum_q == feed) ? EV_GOOD : EV_BAD;
      fr_len      = FULL_LEN;
      fr_in_frame = 1'b0;
      fr_fpos     = '0;
      fr_rsum     = '0;
      fr_lws      = 1'b0;
    end
  end

  assign hist_new = hist_vld_q[hist_idx_q] ? sat_inc(hist_rd_q) : CNT_W'(1);
  assign rx_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    mpos_d      = mpos_q;
    in_frame_d  = in_frame_q;
    lws_d       = lws_q;
    fpos_d      = fpos_q;
    rsum_d      = rsum_q;
    good_d      = good_q;
    bad_d       = bad_q;
    inc_d       = inc_q;
    ntf_d       = ntf_q;
    pay_d       = pay_q;
    rep_idx_d   = rep_idx_q;
    rep_cnt_d   = rep_cnt_q;
    cur_pend_d  = cur_pend_q;
    cur_d       = cur_q;
    ev_vld_d    = ev_vld_q;
    ev_kind_d   = ev_kind_q;
    ev_len_d    = ev_len_q;
    ev_csum_d   = ev_csum_q;
    ev_rsum_d   = ev_rsum_q;
    ev_hist_d   = ev_hist_q;
    hist_post_d = hist_post_q;
    hist_idx_d  = hist_idx_q;
    hist_vld_d  = hist_vld_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    hist_we     = 1'b0;
    hist_rd_en  = 1'b0;

    if (out_vld_q && ev_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (rx_i.valid) begin
          ev_vld_d    = 1'b0;
          hist_post_d = 1'b0;
          ev_hist_d   = '0;
          cur_d       = rx_i.rx_byte;
          rep_idx_d   = '0;
          if (mpos_q == '0) begin
            if (rx_i.rx_byte == pattern_byte(PAT_FIRST)) begin
              mpos_d = MPOS_W'(1);
            end else begin
              rep_cnt_d  = '0;
              cur_pend_d = 1'b1;
              state_d    = S_FEED;
            end
          end else if (rx_i.rx_byte == pattern_byte(mpos_q)) begin
            if (mpos_q == PAT_LAST) begin
              ntf_d  = sat_inc(ntf_q);
              mpos_d = '0;
            end else begin
              mpos_d = mpos_q + MPOS_W'(1);
            end
          end else begin
            rep_cnt_d = mpos_q;
            if (rx_i.rx_byte == pattern_byte(PAT_FIRST)) begin
              mpos_d     = MPOS_W'(1);
              cur_pend_d = 1'b0;
            end else begin
              mpos_d     = '0;
              cur_pend_d = 1'b1;
            end
            state_d = S_FEED;
          end
        end
      end
      S_FEED: begin
        in_frame_d = fr_in_frame;
        lws_d      = fr_lws;
        fpos_d     = fr_fpos;
        rsum_d     = fr_rsum;
        pay_d      = sat_inc(pay_q);
        if (rep_idx_q < rep_cnt_q) begin
          rep_idx_d = rep_idx_q + MPOS_W'(1);
        end else begin
          cur_pend_d = 1'b0;
        end
        if (fr_ev) begin
          case (fr_kind)
            EV_GOOD:       good_d = sat_inc(good_q);
            EV_BAD:        bad_d  = sat_inc(bad_q);
            EV_INCOMPLETE: inc_d  = sat_inc(inc_q);
            default:       good_d = good_q;
          endcase
        end
        if (fr_ev && !ev_vld_q) begin
          ev_vld_d    = 1'b1;
          ev_kind_d   = fr_kind;
          ev_len_d    = fr_len;
          ev_hist_d   = '0;
          hist_post_d = (fr_kind == EV_INCOMPLETE);
          if (fr_kind == EV_INCOMPLETE) begin
            ev_csum_d = '0;
            ev_rsum_d = '0;
          end else begin
            ev_csum_d = rsum_q;
            ev_rsum_d = feed;
          end
        end
        if (fr_ev && fr_kind == EV_INCOMPLETE) begin
          hist_rd_en = 1'b1;
          hist_idx_d = HIST_AW'(fr_len);
          state_d    = S_HIST;
        end else if ((rep_idx_d < rep_cnt_q) || cur_pend_d) begin
          state_d = S_FEED;
        end else begin
          state_d = S_DONE;
        end
      end
      S_HIST: begin
        hist_we                = 1'b1;
        hist_vld_d[hist_idx_q] = 1'b1;
        if (hist_post_q) begin
          ev_hist_d = hist_new;
        end
        state_d = ((rep_idx_q < rep_cnt_q) || cur_pend_q) ? S_FEED : S_DONE;
      end
      S_DONE: begin
        if (!ev_vld_q) begin
          state_d = S_IDLE;
        end else if (!out_vld_q || ev_o.ready) begin
          out_vld_d                    = 1'b1;
          out_d.event_kind             = ev_kind_q;
          out_d.frame_length           = ev_len_q;
          out_d.computed_sum           = ev_csum_q;
          out_d.received_sum           = ev_rsum_q;
          out_d.good_total             = good_q;
          out_d.bad_total              = bad_q;
          out_d.incomplete_total       = inc_q;
          out_d.notify_total           = ntf_q;
          out_d.payload_total          = pay_q;
          out_d.length_histogram_count = ev_hist_q;
          state_d                      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mpos_q      <= '0;
      in_frame_q  <= 1'b0;
      lws_q       <= 1'b0;
      fpos_q      <= '0;
      rsum_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      inc_q       <= '0;
      ntf_q       <= '0;
      pay_q       <= '0;
      rep_idx_q   <= '0;
      rep_cnt_q   <= '0;
      cur_pend_q  <= 1'b0;
      cur_q       <= '0;
      ev_vld_q    <= 1'b0;
      ev_kind_q   <= EV_GOOD;
      ev_len_q    <= '0;
      ev_csum_q   <= '0;
      ev_rsum_q   <= '0;
      ev_hist_q   <= '0;
      hist_post_q <= 1'b0;
      hist_idx_q  <= '0;
      hist_vld_q  <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      mpos_q      <= mpos_d;
      in_frame_q  <= in_frame_d;
      lws_q       <= lws_d;
      fpos_q      <= fpos_d;
      rsum_q      <= rsum_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      inc_q       <= inc_d;
      ntf_q       <= ntf_d;
      pay_q       <= pay_d;
      rep_idx_q   <= rep_idx_d;
      rep_cnt_q   <= rep_cnt_d;
      cur_pend_q  <= cur_pend_d;
      cur_q       <= cur_d;
      ev_vld_q    <= ev_vld_d;
      ev_kind_q   <= ev_kind_d;
      ev_len_q    <= ev_len_d;
      ev_csum_q   <= ev_csum_d;
      ev_rsum_q   <= ev_rsum_d;
      ev_hist_q   <= ev_hist_d;
      hist_post_q <= hist_post_d;
      hist_idx_q  <= hist_idx_d;
      hist_vld_q  <= hist_vld_d;
      out_vld_q   <= out_vld_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_idx_q] <= hist_new;
    end
    if (hist_rd_en) begin
      hist_rd_q <= hist_mem[hist_idx_d];
    end
  end

  assign ev_o.valid                  = out_vld_q;
  assign ev_o.event_kind             = out_q.event_kind;
  assign ev_o.frame_length           = out_q.frame_length;
  assign ev_o.computed_sum           = out_q.computed_sum;
  assign ev_o.received_sum           = out_q.received_sum;
  assign ev_o.good_total             = out_q.good_total;
  assign ev_o.bad_total              = out_q.bad_total;
  assign ev_o.incomplete_total       = out_q.incomplete_total;
  assign ev_o.notify_total           = out_q.notify_total;
  assign ev_o.payload_total          = out_q.payload_total;
  assign ev_o.length_histogram_count = out_q.length_histogram_count;

`ifndef SYNTHESIS
  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (fpos_q >= FPOS_W'(2)) && (fpos_q <= LAST_POS))
    else $error("frame position out of range");

  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (fpos_q == '0) && (rsum_q == '0))
    else $error("framer state not cleared while hunting");

  a_match_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpos_q <= PAT_LAST)
    else $error("match position past pattern end");

  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEED || state_q == S_HIST) |-> (rep_idx_q <= rep_cnt_q))
    else $error("replay index past held prefix");

  a_hist_after_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HIST) |-> ($past(state_q) == S_FEED) && ($past(inc_q) != inc_q ||
      inc_q == CNT_MAX))
    else $error("histogram update without incomplete frame");
`endif

endmodule
